@@ sv/ggcs_pkg.sv @@
package ggcs_pkg;

    // largest grid edge the occupancy map is built for
    localparam int C_MAX_DIM  = 32;
    localparam int C_AW       = $clog2(C_MAX_DIM);
    localparam int C_ROWS     = C_MAX_DIM * C_MAX_DIM;
    localparam int C_ROW_AW   = 2 * C_AW;

    // field widths fixed by the interface
    localparam int C_CW       = 5;
    localparam int C_TAG_W    = 16;
    localparam int C_CFG_W    = 6;
    // neighbour arithmetic: coordinate plus offset, and grid sizes up to the map edge
    localparam int C_NW       = C_CW + 2;

    localparam int C_IN_W     = 32;
    localparam int C_OUT_W    = 24;

    // register indexes
    localparam logic [1:0] C_REG_X = 2'd0;
    localparam logic [1:0] C_REG_Y = 2'd1;
    localparam logic [1:0] C_REG_Z = 2'd2;

    localparam logic [C_CFG_W-1:0] C_CFG_RESET = 6'd32;

    // opcodes
    localparam logic C_OP_INSERT = 1'b0;
    localparam logic C_OP_CLEAR  = 1'b1;

    // scan steps over the nine rows of the neighbourhood
    localparam logic [3:0] C_LAST_STEP   = 4'd8;
    localparam logic [3:0] C_CENTER_STEP = 4'd4;

    typedef struct packed {
        logic                load;
        logic                rd_issue;
        logic [3:0]          rd_step;
        logic                clr_wr;
        logic [C_ROW_AW-1:0] clr_row;
        logic                wr_center;
        logic                out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic in_clear;
        logic in_oor;
        logic out_free;
    } t_dp_sts;

    // step to y offset index (0..2 meaning -1..+1)
    function automatic logic [1:0] f_step_dy(input logic [3:0] step);
        logic [1:0] r;
        case (step)
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    // step to z offset index
    function automatic logic [1:0] f_step_dz(input logic [3:0] step);
        logic [1:0] r;
        case (step)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    // effective grid size: zero acts as one, clamp to the map edge
    function automatic logic [C_NW-1:0] f_eff_size(input logic [C_CFG_W-1:0] v);
        logic [C_NW-1:0] w;
        logic [C_NW-1:0] r;
        w = C_NW'(v);
        if (w == '0) begin
            r = C_NW'(1);
        end else if (w > C_NW'(C_MAX_DIM)) begin
            r = C_NW'(C_MAX_DIM);
        end else begin
            r = w;
        end
        return r;
    endfunction

endpackage

@@ sv/ggcs_ctrl.sv @@
module ggcs_ctrl
    import ggcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  t_dp_sts i_sts,
    output logic    o_s_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_WRITE,
        S_DONE
    } t_state;

    localparam logic [C_ROW_AW-1:0] C_LAST_ROW = C_ROW_AW'(C_ROWS - 1);

    t_state              r_state;
    logic [C_ROW_AW-1:0] r_row;
    logic [3:0]          r_step;

    always_comb begin
        o_cmd     = '0;
        o_s_ready = (r_state == S_IDLE);
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr  = 1'b1;
                o_cmd.clr_row = r_row;
            end
            S_IDLE: begin
                o_cmd.load = i_s_valid;
            end
            S_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.rd_step  = r_step;
            end
            S_WRITE: begin
                o_cmd.wr_center = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_row   <= '0;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_row <= r_row + 1'b1;
                    if (r_row == C_LAST_ROW) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_valid) begin
                        if (i_sts.in_clear) begin
                            r_row   <= '0;
                            r_state <= S_CLEAR;
                        end else if (i_sts.in_oor) begin
                            r_state <= S_DONE;
                        end else begin
                            r_step  <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == C_LAST_STEP) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // single map port: never a read and a write in one cycle
    a_one_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.rd_issue && (o_cmd.clr_wr || o_cmd.wr_center)))
        else $error("map read and write collide");

    // a result is only loaded into a free output slot
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a waiting word");

    // a clear opcode starts the clearing pass and blocks input
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_ready && i_s_valid && i_sts.in_clear) |=> !o_s_ready)
        else $error("input taken during clearing pass");

    // scan never runs past the ninth row
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_issue |-> (o_cmd.rd_step <= C_LAST_STEP))
        else $error("scan step out of bounds");

endmodule

@@ sv/ggcs_dp.sv @@
module ggcs_dp
    import ggcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [C_IN_W-1:0]  i_s_data,
    input  logic               i_s_user,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [C_CFG_W-1:0] i_cfg_data,
    input  logic               i_m_ready,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic               o_m_valid,
    output logic [C_OUT_W-1:0] o_m_data
);

    // configuration
    logic [C_CFG_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [C_NW-1:0]    sx, sy, sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= C_CFG_RESET;
            r_size_y <= C_CFG_RESET;
            r_size_z <= C_CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                C_REG_X: r_size_x <= i_cfg_data;
                C_REG_Y: r_size_y <= i_cfg_data;
                C_REG_Z: r_size_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign sx = f_eff_size(r_size_x);
    assign sy = f_eff_size(r_size_y);
    assign sz = f_eff_size(r_size_z);

    // input decode
    logic [C_NW-1:0]    in_x, in_y, in_z;
    logic [C_TAG_W-1:0] in_tag;

    assign in_x   = C_NW'(i_s_data[C_CW-1:0]);
    assign in_y   = C_NW'(i_s_data[2*C_CW-1:C_CW]);
    assign in_z   = C_NW'(i_s_data[3*C_CW-1:2*C_CW]);
    assign in_tag = i_s_data[3*C_CW+C_TAG_W-1:3*C_CW];

    assign o_sts.in_clear = (i_s_user == C_OP_CLEAR);
    assign o_sts.in_oor   = (in_x >= sx) || (in_y >= sy) || (in_z >= sz);

    // item registers
    logic [C_NW-1:0]    r_x, r_y, r_z;
    logic [C_TAG_W-1:0] r_tag;
    logic               r_oor;
    logic               r_hit;
    logic [C_MAX_DIM-1:0] r_center_row;

    // neighbour row address for the current scan step
    logic [C_NW-1:0]     nyp, nzp, ny, nz;
    logic                row_ok;
    logic [C_ROW_AW-1:0] scan_addr, center_addr;

    assign nyp       = r_y + C_NW'(f_step_dy(i_cmd.rd_step));
    assign nzp       = r_z + C_NW'(f_step_dz(i_cmd.rd_step));
    assign ny        = nyp - 1'b1;
    assign nz        = nzp - 1'b1;
    assign row_ok    = (nyp != '0) && (nyp <= sy) && (nzp != '0) && (nzp <= sz);
    assign scan_addr = {nz[C_AW-1:0], ny[C_AW-1:0]};
    assign center_addr = {r_z[C_AW-1:0], r_y[C_AW-1:0]};

    // occupancy map, one row of x cells per word
    logic [C_MAX_DIM-1:0] mem [C_ROWS];
    logic [C_MAX_DIM-1:0] r_rdata;
    logic                 mem_we;
    logic [C_ROW_AW-1:0]  mem_addr;
    logic [C_MAX_DIM-1:0] mem_wdata;
    logic [C_MAX_DIM-1:0] x_mask;

    always_comb begin
        x_mask = '0;
        x_mask[r_x[C_AW-1:0]] = 1'b1;
    end

    assign mem_we    = i_cmd.clr_wr || (i_cmd.wr_center && !r_hit);
    assign mem_addr  = i_cmd.clr_wr    ? i_cmd.clr_row :
                       i_cmd.wr_center ? center_addr   : scan_addr;
    assign mem_wdata = i_cmd.clr_wr ? '0 : (r_center_row | x_mask);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    // read tracking, registered read data arrives in the cycle after the address
    logic r_rd_pend, r_rd_ok, r_rd_ctr;
    logic row_hit;

    always_comb begin
        logic [C_NW-1:0] nxp;
        logic [C_NW-1:0] nx;
        row_hit = 1'b0;
        for (int d = 0; d < 3; d++) begin
            nxp = r_x + C_NW'(d);
            nx  = nxp - 1'b1;
            if ((nxp != '0) && (nxp <= sx) && r_rdata[nx[C_AW-1:0]]) begin
                row_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_ok  <= row_ok;
        r_rd_ctr <= (i_cmd.rd_step == C_CENTER_STEP);
        if (i_cmd.load) begin
            r_x   <= in_x;
            r_y   <= in_y;
            r_z   <= in_z;
            r_tag <= in_tag;
            r_oor <= o_sts.in_oor;
            r_hit <= 1'b0;
        end else if (r_rd_pend) begin
            r_hit <= r_hit | (r_rd_ok & row_hit);
            if (r_rd_ctr) begin
                r_center_row <= r_rdata;
            end
        end
    end

    // output register
    logic               r_out_valid;
    logic [C_TAG_W-1:0] r_out_tag;
    logic               r_out_acc, r_out_oor;

    assign o_sts.out_free = !r_out_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_tag <= r_tag;
            r_out_acc <= !r_oor && !r_hit;
            r_out_oor <= r_oor;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = {6'd0, r_out_oor, r_out_acc, r_out_tag};

endmodule

@@ sv/greedy_grid_cube_separation.sv @@
// channel | dir | handshake          | contents
// input   | in  | s_tvalid/s_tready  | s_tuser opcode, s_tdata cube x, y, z, tag
// result  | out | m_tvalid/m_tready  | m_tdata tag, accepted, out_of_range
// config  | in  | i_cfg_we           | i_cfg_idx grid size x/y/z, i_cfg_data
//
// a test-and-insert word steps through: accept, nine row reads of the single-port
// occupancy map (one per y/z neighbour row), evaluation, a write-back on no hit, result
// out-of-grid words go straight to a result; a clear word wipes the 1024 map rows in turn
// after reset the map is swept clean, all 1024 rows, before the first word is taken
// one result word may wait in the output register while the next word is worked on;
// a stalled result holds the block only at the end of that next word
module greedy_grid_cube_separation
    import ggcs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input word
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [C_IN_W-1:0]  s_tdata,   // cube_x[4:0], cube_y[9:5], cube_z[14:10],
                                          // cube_tag[30:15], zero[31]
    input  logic               s_tuser,   // opcode
    // result word
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [C_OUT_W-1:0] m_tdata,   // result_tag[15:0], accepted[16],
                                          // out_of_range[17], zero[23:18]
    // configuration writes
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [C_CFG_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencer: clearing sweep, nine-row scan, write-back, result hand-off
    ggcs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_sts     (sts),
        .o_s_ready (s_tready),
        .o_cmd     (cmd)
    );

    // map memory, bounds checks, hit accumulation and the output register
    ggcs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_data   (s_tdata),
        .i_s_user   (s_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_m_ready  (m_tready),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_valid  (m_tvalid),
        .o_m_data   (m_tdata)
    );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import ggcs_pkg::*;

    // cycles with no word moving on either side before the run is declared hung;
    // a clear word alone is silent while it sweeps the whole map
    localparam int IDLE_LIMIT    = 5000;
    // quiet time after the last result: covers a clear still sweeping the map
    localparam int SETTLE_CYCLES = 1100;
    // long receiver hold-off that backs the block up into its input
    localparam int HOLD_CYCLES   = 400;
    // index past the register list, writes to it must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // one expected result word
    typedef struct packed {
        logic [C_TAG_W-1:0] tag;
        logic               kept;
        logic               outside;
    } t_cube_verdict;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               s_tvalid   = 1'b0;
    logic               s_tready;
    logic [C_IN_W-1:0]  s_tdata    = '0;   // cube_x, cube_y, cube_z, cube_tag, zero
    logic               s_tuser    = 1'b0; // opcode
    logic               m_tvalid;
    logic               m_tready   = 1'b0;
    logic [C_OUT_W-1:0] m_tdata;           // result_tag, accepted, out_of_range, zero
    logic               i_cfg_we   = 1'b0;
    logic [1:0]         i_cfg_idx  = '0;
    logic [C_CFG_W-1:0] i_cfg_data = '0;

    // own copy of the block state: grid registers and the occupancy bitmap
    logic [C_CFG_W-1:0] grid_x = C_CFG_RESET;
    logic [C_CFG_W-1:0] grid_y = C_CFG_RESET;
    logic [C_CFG_W-1:0] grid_z = C_CFG_RESET;
    bit                 occ_map [C_MAX_DIM*C_MAX_DIM*C_MAX_DIM];

    t_cube_verdict verdict_q [$];
    t_cube_verdict head_v;
    int            mismatches  = 0;
    int            idle_cycles = 0;

    // calm: neither side idles; hold_seq bumps request a receiver hold-off
    logic          calm      = 1'b0;
    int            hold_seq  = 0;
    int            hold_seen = 0;
    int            hold_left = 0;

    // last in-grid cube, used to cluster cubes so that neighbours really collide
    int            last_x = 0;
    int            last_y = 0;
    int            last_z = 0;

    greedy_grid_cube_separation dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // grid size as the block uses it: zero acts as one, clamp to the map edge
    function automatic int eff_dim(input logic [C_CFG_W-1:0] v);
        int d;
        d = int'(v);
        if (d < 1) d = 1;
        if (d > C_MAX_DIM) d = C_MAX_DIM;
        return d;
    endfunction

    function automatic int cell_index(input int cx, input int cy, input int cz);
        return (cz * C_MAX_DIM + cy) * C_MAX_DIM + cx;
    endfunction

    // coordinate within two cells of c, kept inside the grid
    function automatic logic [C_CW-1:0] jitter_coord(input int c, input int lim);
        int v;
        v = c + int'($urandom_range(4)) - 2;
        if (v > lim - 1) v = lim - 1;
        if (v < 0) v = 0;
        return C_CW'(v);
    endfunction

    // apply one accepted word to the bitmap and queue the result it must produce
    task automatic judge_word(input logic op, input logic [C_CW-1:0] x, y, z,
                              input logic [C_TAG_W-1:0] tag);
        t_cube_verdict v;
        int            sx, sy, sz, nx, ny, nz, dx, dy, dz;
        bit            hit;
        sx  = eff_dim(grid_x);
        sy  = eff_dim(grid_y);
        sz  = eff_dim(grid_z);
        hit = 1'b0;
        if (op == C_OP_CLEAR) begin
            // clear empties the map and answers nothing
            foreach (occ_map[i]) occ_map[i] = 1'b0;
        end else begin
            v.tag     = tag;
            v.kept    = 1'b0;
            v.outside = 1'b0;
            if (int'(x) >= sx || int'(y) >= sy || int'(z) >= sz) begin
                v.outside = 1'b1;
            end else begin
                // neighbours off the grid edge are skipped, nothing wraps
                for (dz = -1; dz <= 1; dz++) begin
                    for (dy = -1; dy <= 1; dy++) begin
                        for (dx = -1; dx <= 1; dx++) begin
                            nx = int'(x) + dx;
                            ny = int'(y) + dy;
                            nz = int'(z) + dz;
                            if (nx >= 0 && ny >= 0 && nz >= 0 &&
                                nx < sx && ny < sy && nz < sz &&
                                occ_map[cell_index(nx, ny, nz)])
                                hit = 1'b1;
                        end
                    end
                end
                if (!hit) occ_map[cell_index(int'(x), int'(y), int'(z))] = 1'b1;
                v.kept = !hit;
            end
            verdict_q = {verdict_q, v};
        end
    endtask

    // offer one word, possibly after a short gap, and wait for the handshake;
    // tvalid is left high so back-to-back words need no second assignment
    task automatic send_word(input logic op, input logic [C_CW-1:0] x, y, z,
                             input logic [C_TAG_W-1:0] tag);
        int gap;
        if (!calm && $urandom_range(99) < 24) begin
            gap = $urandom_range(20, 1);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, tag, z, y, x};
        do @(posedge i_clk); while (!s_tready);
        judge_word(op, x, y, z, tag);
    endtask

    task automatic insert_cube(input int x, input int y, input int z, input int tag);
        send_word(C_OP_INSERT, C_CW'(x), C_CW'(y), C_CW'(z), C_TAG_W'(tag));
    endtask

    task automatic clear_map();
        send_word(C_OP_CLEAR, C_CW'($urandom), C_CW'($urandom), C_CW'($urandom),
                  C_TAG_W'($urandom));
    endtask

    // drop tvalid, let every result come back, then let a pending clear finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one register write; the caller lowers the write enable after its last write
    task automatic write_reg(input logic [1:0] idx, input logic [C_CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            C_REG_X: grid_x = val;
            C_REG_Y: grid_y = val;
            C_REG_Z: grid_z = val;
            default: ;
        endcase
    endtask

    task automatic set_grid(input int sx, input int sy, input int sz);
        wait_idle();
        write_reg(C_REG_X, C_CFG_W'(sx));
        write_reg(C_REG_Y, C_CFG_W'(sy));
        write_reg(C_REG_Z, C_CFG_W'(sz));
        i_cfg_we <= 1'b0;
    endtask

    // full 32 grid from reset: corners, neighbour hits, and the places where
    // linear address arithmetic would wrap across a row or a plane
    task automatic test_directed_cubes();
        insert_cube(0, 0, 0, 16'h0000);
        insert_cube(1, 1, 1, 16'hffff);
        insert_cube(31, 31, 31, 16'h8001);
        insert_cube(30, 30, 30, 16'h7ffe);
        insert_cube(2, 0, 0, 16'h1234);
        clear_map();
        insert_cube(31, 0, 0, 16'h0001);
        // x - 1 from here is off the grid, not the end of the previous row
        insert_cube(0, 1, 0, 16'h0002);
        insert_cube(5, 31, 3, 16'h0003);
        // y - 1 from here is off the grid, not the last row of the previous plane
        insert_cube(5, 0, 4, 16'h0004);
        clear_map();
        insert_cube(0, 0, 0, 16'haaaa);
        insert_cube(31, 0, 0, 16'h5555);
    endtask

    // small grids, out-of-grid coordinates, shrinking over old marks,
    // register values out of range and a write to an unused index
    task automatic test_grid_edges();
        set_grid(6, 6, 6);
        clear_map();
        insert_cube(5, 5, 5, 16'h0101);
        insert_cube(4, 4, 4, 16'h0102);
        insert_cube(6, 0, 0, 16'h0103);
        insert_cube(0, 6, 0, 16'h0104);
        insert_cube(0, 0, 6, 16'h0105);
        // mark at x = 5 now lies outside and must not block its old neighbour
        set_grid(5, 32, 32);
        insert_cube(4, 4, 4, 16'h0201);
        insert_cube(5, 5, 5, 16'h0202);
        // zero acts as one, 63 clamps to the map edge
        wait_idle();
        write_reg(C_REG_X, 6'd0);
        write_reg(C_REG_Y, 6'd63);
        write_reg(C_REG_Z, 6'd1);
        write_reg(REG_UNUSED, 6'd20);
        i_cfg_we <= 1'b0;
        insert_cube(0, 0, 0, 16'h0301);
        insert_cube(1, 0, 0, 16'h0302);
        insert_cube(0, 31, 0, 16'h0303);
        insert_cube(0, 0, 1, 16'h0304);
        insert_cube(0, 0, 0, 16'h0305);
    endtask

    // mostly in-grid cubes clustered round the last one, plus whole-range
    // coordinates, deliberate out-of-grid cubes and the odd clear
    task automatic run_random_phase(input int count);
        int               sx, sy, sz, r;
        logic [C_CW-1:0]  x, y, z;
        sx = eff_dim(grid_x);
        sy = eff_dim(grid_y);
        sz = eff_dim(grid_z);
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 3) begin
                clear_map();
            end else begin
                if (r < 13) begin
                    x = C_CW'($urandom);
                    y = C_CW'($urandom);
                    z = C_CW'($urandom);
                end else if (r < 20 && (sx < C_MAX_DIM || sy < C_MAX_DIM ||
                                        sz < C_MAX_DIM)) begin
                    x = (sx < C_MAX_DIM) ? C_CW'($urandom_range(31, sx))
                                         : C_CW'($urandom_range(sx - 1));
                    y = (sy < C_MAX_DIM) ? C_CW'($urandom_range(31, sy))
                                         : C_CW'($urandom_range(sy - 1));
                    z = (sz < C_MAX_DIM) ? C_CW'($urandom_range(31, sz))
                                         : C_CW'($urandom_range(sz - 1));
                end else begin
                    if ($urandom_range(1) == 1) begin
                        x = jitter_coord(last_x, sx);
                        y = jitter_coord(last_y, sy);
                        z = jitter_coord(last_z, sz);
                    end else begin
                        x = C_CW'($urandom_range(sx - 1));
                        y = C_CW'($urandom_range(sy - 1));
                        z = C_CW'($urandom_range(sz - 1));
                    end
                    last_x = int'(x);
                    last_y = int'(y);
                    last_z = int'(z);
                end
                send_word(C_OP_INSERT, x, y, z, C_TAG_W'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        set_grid(32, 32, 32);
        run_random_phase(110);
        set_grid(4, 4, 4);
        run_random_phase(110);
        set_grid(3, 1, 32);
        run_random_phase(110);
        set_grid(63, 40, 2);
        run_random_phase(110);
        // a stretch with no idling on either side
        set_grid(8, 8, 8);
        calm <= 1'b1;
        run_random_phase(110);
        calm <= 1'b0;
        set_grid(0, 5, 33);
        run_random_phase(110);
        set_grid(6, 6, 6);
        run_random_phase(110);
    endtask

    // receiver holds off for a long while, sender keeps pushing words back to back
    task automatic test_result_stall();
        set_grid(16, 16, 16);
        calm     <= 1'b1;
        hold_seq <= hold_seq + 1;
        run_random_phase(60);
        calm     <= 1'b0;
    endtask

    // receiver: random stalls, a calm stretch, and the counted long hold-off
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (calm) begin
            m_tready  <= 1'b1;
        end else begin
            m_tready  <= ($urandom_range(99) >= 24);
        end
    end

    // result checker: every result word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                head_v = verdict_q.pop_front();
                if (m_tdata[15:0] !== head_v.tag) begin
                    $display("%0t: result_tag expected %h actual %h",
                             $time, head_v.tag, m_tdata[15:0]);
                    mismatches++;
                end
                if (m_tdata[16] !== head_v.kept) begin
                    $display("%0t: accepted expected %b actual %b (tag %h)",
                             $time, head_v.kept, m_tdata[16], head_v.tag);
                    mismatches++;
                end
                if (m_tdata[17] !== head_v.outside) begin
                    $display("%0t: out_of_range expected %b actual %b (tag %h)",
                             $time, head_v.outside, m_tdata[17], head_v.tag);
                    mismatches++;
                end
            end
        end
    end

    // watchdog: nothing moving on either side for too long means a hang
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        // single synchronous reset; the block then sweeps its map before taking words
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cubes();
        test_grid_edges();
        test_random_traffic();
        test_result_stall();
        wait_idle();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/ggcs_pkg.sv
sv/ggcs_ctrl.sv
sv/ggcs_dp.sv
sv/greedy_grid_cube_separation.sv
bench/testbench.sv
